/* hdl/efad_pkg.sv */
// Shared types and constants for the encoder frame angle decoder.
// No dependencies; imported by every module of the block.
package efad_pkg;

  // Default longest frame that the byte position counter tracks
  localparam int unsigned MAX_FRAME_BYTES = 256;

  // Depth of the job queue between front and back (power of two)
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // 2*pi in unsigned Q8.24, truncated
  localparam logic [31:0] TWO_PI_Q8_24 = 32'h0648_7ED5;

  // Configuration register indexes
  localparam logic [2:0] REG_FIELD_OFFSET     = 3'd0;
  localparam logic [2:0] REG_FIELD_BYTE_COUNT = 3'd1;
  localparam logic [2:0] REG_FIELD_BIT_COUNT  = 3'd2;
  localparam logic [2:0] REG_BIG_ENDIAN       = 3'd3;
  localparam logic [2:0] REG_FULL_SCALE       = 3'd4;

  // Reset values of the configuration registers
  localparam logic [7:0]  RST_FIELD_OFFSET     = 8'd0;
  localparam logic [2:0]  RST_FIELD_BYTE_COUNT = 3'd2;
  localparam logic [5:0]  RST_FIELD_BIT_COUNT  = 6'd16;
  localparam logic        RST_BIG_ENDIAN       = 1'b0;
  localparam logic [31:0] RST_FULL_SCALE       = 32'd0;

  // One finished frame handed from front to back
  typedef struct packed {
    logic        err;        // bad configuration or short frame
    logic [5:0]  bit_count;  // shift amount, 1..32 when err is clear
    logic [31:0] raw;        // field value, already masked
    logic [31:0] scale;      // full scale, zero already replaced by 2*pi
  } job_t;

endpackage

/* hdl/efad_front.sv */
// Front part: holds the configuration registers, accepts frame bytes,
// assembles the angle field and queues one job per frame. Uses efad_pkg.
module efad_front import efad_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MAX_FRAME_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        byte_valid_i,
  output logic        byte_ready_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        last_byte_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output job_t        job_o
);

  localparam int unsigned PosW = $clog2(MaxFrameBytes + 1);
  localparam int unsigned CmpW = (PosW > 8) ? PosW : 8;
  localparam logic [PosW-1:0] PosMax = PosW'(MaxFrameBytes);

  logic [7:0]  field_offset_q;
  logic [2:0]  field_byte_count_q;
  logic [5:0]  field_bit_count_q;
  logic        big_endian_q;
  logic [31:0] full_scale_q;

  logic [PosW-1:0] byte_position_q, byte_position_d;
  logic [31:0]     raw_q, raw_d;
  logic [2:0]      captured_q, captured_d;

  logic            accept;
  logic            count_ok, bits_ok;
  logic [CmpW-1:0] pos_ext, off_ext, idx;
  logic            take;
  logic [31:0]     le_byte;
  logic [31:0]     mask;
  logic [5:0]      mask_shift;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_offset_q     <= RST_FIELD_OFFSET;
      field_byte_count_q <= RST_FIELD_BYTE_COUNT;
      field_bit_count_q  <= RST_FIELD_BIT_COUNT;
      big_endian_q       <= RST_BIG_ENDIAN;
      full_scale_q       <= RST_FULL_SCALE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FIELD_OFFSET:     field_offset_q     <= cfg_data_i[7:0];
        REG_FIELD_BYTE_COUNT: field_byte_count_q <= cfg_data_i[2:0];
        REG_FIELD_BIT_COUNT:  field_bit_count_q  <= cfg_data_i[5:0];
        REG_BIG_ENDIAN:       big_endian_q       <= cfg_data_i[0];
        REG_FULL_SCALE:       full_scale_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign byte_ready_o = !queue_full_i;
  assign accept       = byte_valid_i && byte_ready_o;

  assign count_ok = (field_byte_count_q >= 3'd1) && (field_byte_count_q <= 3'd4);
  assign bits_ok  = (field_bit_count_q >= 6'd1) && (field_bit_count_q <= 6'd32);

  // Locate the byte within the field
  assign pos_ext = CmpW'(byte_position_q);
  assign off_ext = CmpW'(field_offset_q);
  assign idx     = pos_ext - off_ext;
  assign take    = (byte_position_q < PosMax) && count_ok && (pos_ext >= off_ext)
                   && (idx < CmpW'(field_byte_count_q)) && (captured_q < 3'd4);
  assign le_byte = {24'd0, frame_byte_i} << {idx[1:0], 3'b000};

  // Assemble the field and advance the saturating position
  always_comb begin
    raw_d           = raw_q;
    captured_d      = captured_q;
    byte_position_d = byte_position_q;
    if (take) begin
      raw_d      = big_endian_q ? {raw_q[23:0], frame_byte_i} : (raw_q | le_byte);
      captured_d = captured_q + 3'd1;
    end
    if (byte_position_q < PosMax) begin
      byte_position_d = byte_position_q + PosW'(1);
    end
  end

  // Keep only the significant bits
  assign mask_shift = 6'd32 - field_bit_count_q;
  assign mask       = 32'hFFFF_FFFF >> mask_shift[4:0];

  // Build the job for the last byte of a frame
  always_comb begin
    job_o.err       = !count_ok || !bits_ok || (captured_d != field_byte_count_q);
    job_o.bit_count = field_bit_count_q;
    job_o.raw       = (field_bit_count_q >= 6'd32) ? raw_d : (raw_d & mask);
    job_o.scale     = (full_scale_q == 32'd0) ? TWO_PI_Q8_24 : full_scale_q;
  end

  assign push_o = accept && last_byte_i;

  // Frame state; clear after every result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_position_q <= '0;
      raw_q           <= '0;
      captured_q      <= '0;
    end else if (accept) begin
      if (last_byte_i) begin
        byte_position_q <= '0;
        raw_q           <= '0;
        captured_q      <= '0;
      end else begin
        byte_position_q <= byte_position_d;
        raw_q           <= raw_d;
        captured_q      <= captured_d;
      end
    end
  end

endmodule

/* hdl/efad_queue.sv */
// Short job queue between front and back of the angle decoder.
// Uses efad_pkg for the job type and depth.
module efad_queue import efad_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output job_t data_o
);

  job_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Store jobs
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + (QUEUE_AW+1)'(1);
        2'b01:   count_q <= count_q - (QUEUE_AW+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

/* hdl/efad_back.sv */
// Back part: multiplies the field by full scale, shifts by the bit count
// and holds the result for the output channel. Uses efad_pkg.
module efad_back import efad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        queue_empty_i,
  input  job_t        job_i,
  output logic        pop_o,
  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic [31:0] angle_o,
  output logic        status_o
);

  logic        mul_valid_q;
  logic [63:0] prod_q;
  logic [5:0]  bit_count_q;
  logic        err_q;

  logic        out_valid_q;
  logic [31:0] angle_q;
  logic        status_q;

  logic        out_advance, mul_advance;
  logic [63:0] shifted;

  assign out_advance = !out_valid_q || result_ready_i;
  assign mul_advance = !mul_valid_q || out_advance;
  assign pop_o       = !queue_empty_i && mul_advance;

  // Multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (mul_advance) begin
      mul_valid_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_advance && pop_o) begin
      prod_q      <= 64'(job_i.raw) * 64'(job_i.scale);
      bit_count_q <= job_i.bit_count;
      err_q       <= job_i.err;
    end
  end

  // Scale down by the bit count
  assign shifted = prod_q >> bit_count_q;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_advance) begin
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_advance && mul_valid_q) begin
      angle_q  <= err_q ? 32'd0 : shifted[31:0];
      status_q <= err_q;
    end
  end

  assign result_valid_o = out_valid_q;
  assign angle_o        = angle_q;
  assign status_o       = status_q;

endmodule

/* hdl/encoder_frame_angle_decoder.sv */
// Encoder frame angle decoder: takes one frame byte per cycle while the job queue is not full.
// A frame's result passes through the job queue entry, the registered
// multiply stage and the output register after its last byte is accepted.
// Results leave at up to one per cycle; the four-entry queue absorbs stalls.
// Reset clears frame state, queue and pipeline and restores register defaults.
module encoder_frame_angle_decoder import efad_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MAX_FRAME_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] angle
  output logic        m_axis_tuser    // [0] status
);

  logic push, pop, full, empty;
  job_t job_in, job_out;

  efad_front #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .frame_byte_i (s_axis_tdata),
    .last_byte_i  (s_axis_tlast),
    .queue_full_i (full),
    .push_o       (push),
    .job_o        (job_in)
  );

  efad_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .data_o  (job_out)
  );

  efad_back u_back (
    .clk_i,
    .rst_ni,
    .queue_empty_i  (empty),
    .job_i          (job_out),
    .pop_o          (pop),
    .result_valid_o (m_axis_tvalid),
    .result_ready_i (m_axis_tready),
    .angle_o        (m_axis_tdata),
    .status_o       (m_axis_tuser)
  );

endmodule

/* tb/encoder_frame_angle_decoder_tb.sv */
// Self-checking testbench for encoder_frame_angle_decoder: directed frames, then random frames.
// Expected angles come from an in-bench frame decoder; depends on efad_pkg and the block RTL.
`timescale 1ns / 100ps

module encoder_frame_angle_decoder_tb;
  import efad_pkg::*;

  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS    = 1600;
  localparam int unsigned MIN_PHASES      = 22;
  localparam int unsigned NUM_DIRECTED    = 41;

  typedef struct packed {
    logic [31:0] angle;
    logic        status;
  } angle_result_t;

  typedef enum logic {
    ROW_CFG,
    ROW_ITEM
  } row_kind_e;

  // One directed step: a register write or a frame byte, optionally with a typed-in result
  typedef struct {
    row_kind_e   kind;
    logic [2:0]  reg_idx;    // unused on item rows
    logic [31:0] value;      // register value, or frame byte in [7:0]
    logic        last;
    bit          check;
    logic [31:0] exp_angle;
    logic        exp_status;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] frame_byte
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] angle
  logic        m_axis_tuser;   // [0] status

  // Register mirror
  logic [7:0]  cfg_offset;
  logic [2:0]  cfg_byte_count;
  logic [5:0]  cfg_bit_count;
  logic        cfg_big_endian;
  logic [31:0] cfg_full_scale;

  // Frame state of the decoder model
  int unsigned frame_pos;
  logic [31:0] field_acc;
  int unsigned field_bytes_seen;

  angle_result_t angle_q[$];
  stim_row_t     directed_rows [NUM_DIRECTED];
  int unsigned   failures;
  int unsigned   stall_cycles;
  int unsigned   random_items;
  bit            calm;
  bit            hold_off_req;

  encoder_frame_angle_decoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Advance the frame model by one byte; return 1 when the byte closes a frame
  function automatic bit frame_byte_to_angle(input logic [7:0] fb, input logic lb,
                                             output angle_result_t res);
    bit          count_ok;
    bit          bits_ok;
    int unsigned idx;
    logic [63:0] raw;
    logic [63:0] scale;
    logic [63:0] prod;
    count_ok = cfg_byte_count >= 1 && cfg_byte_count <= 4;
    bits_ok  = cfg_bit_count >= 1 && cfg_bit_count <= 32;
    res      = '0;
    // Capture field bytes; the position counter sticks at the frame limit
    if (frame_pos < MAX_FRAME_BYTES) begin
      if (count_ok && frame_pos >= cfg_offset) begin
        idx = frame_pos - cfg_offset;
        if (idx < cfg_byte_count && field_bytes_seen < 4) begin
          if (cfg_big_endian) field_acc = {field_acc[23:0], fb};
          else field_acc = field_acc | ({24'd0, fb} << (8 * idx));
          field_bytes_seen++;
        end
      end
      frame_pos++;
    end
    if (!lb) return 1'b0;
    if (!count_ok || !bits_ok || field_bytes_seen != cfg_byte_count) begin
      res.angle  = '0;
      res.status = 1'b1;
    end else begin
      raw   = {32'd0, field_acc};
      scale = {32'd0, (cfg_full_scale != 0) ? cfg_full_scale : TWO_PI_Q8_24};
      if (cfg_bit_count < 6'd32) raw = raw & ((64'd1 << cfg_bit_count) - 64'd1);
      prod       = (raw * scale) >> cfg_bit_count;
      res.angle  = prod[31:0];
      res.status = 1'b0;
    end
    frame_pos        = 0;
    field_acc        = '0;
    field_bytes_seen = 0;
    return 1'b1;
  endfunction

  // Offer one item, wait for the handshake, then queue what it should produce
  task automatic send_item(input logic [7:0] fb, input logic lb, input bit typed,
                           input angle_result_t typed_res);
    angle_result_t res;
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= fb;
    s_axis_tlast  <= lb;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (frame_byte_to_angle(fb, lb, res)) angle_q.push_back(typed ? typed_res : res);
  endtask

  // Drop valid and hold until every queued result has come out
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_FIELD_OFFSET:     cfg_offset     = val[7:0];
      REG_FIELD_BYTE_COUNT: cfg_byte_count = val[2:0];
      REG_FIELD_BIT_COUNT:  cfg_bit_count  = val[5:0];
      REG_BIG_ENDIAN:       cfg_big_endian = val[0];
      REG_FULL_SCALE:       cfg_full_scale = val;
      default: ;
    endcase
  endtask

  task automatic send_frame(input int unsigned len);
    angle_result_t unused_res;
    unused_res = '0;
    for (int unsigned i = 0; i < len; i++) begin
      send_item(8'($urandom_range(255)), i == len - 1, 1'b0, unused_res);
    end
  endtask

  // One random phase: drain, program all registers, then a burst of frames
  task automatic run_random_phase(input int unsigned phase_no);
    int unsigned mode;
    int unsigned num_frames;
    int unsigned len;
    int unsigned field_end;
    logic [7:0]  off;
    logic [2:0]  bc;
    logic [5:0]  bits;
    logic        be;
    logic [31:0] fs;
    mode    = $urandom_range(99);
    off     = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
    bc      = 3'($urandom_range(1, 4));
    bits    = 6'($urandom_range(1, 32));
    be      = 1'($urandom_range(1));
    case ($urandom_range(9))
      0, 1:    fs = '0;
      2:       fs = '1;
      default: fs = $urandom();
    endcase
    // Mix in bad byte counts, bad bit counts and the bit count extremes
    if (mode < 6) bc = ($urandom_range(3) == 0) ? 3'd0 : 3'($urandom_range(5, 7));
    else if (mode < 12) bits = ($urandom_range(3) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
    else if (mode < 20) bits = $urandom_range(1) ? 6'd1 : 6'd32;
    num_frames = $urandom_range(3, 10);
    // Field reaching past the frame limit
    if (phase_no == 3) begin
      off        = 8'($urandom_range(250, 255));
      bc         = 3'($urandom_range(1, 4));
      num_frames = 2;
    end
    // Output stalled for a long stretch with one-byte frames
    if (phase_no == 7) begin
      off        = '0;
      bc         = 3'd1;
      bits       = 6'd8;
      num_frames = 40;
    end
    // Position counter held at its limit well past where it could wrap
    if (phase_no == 11) begin
      off        = 8'($urandom_range(3));
      bc         = 3'($urandom_range(1, 4));
      bits       = 6'($urandom_range(1, 32));
      num_frames = 1;
    end
    wait_idle();
    write_reg(REG_FIELD_OFFSET, {24'd0, off});
    write_reg(REG_FIELD_BYTE_COUNT, {29'd0, bc});
    write_reg(REG_FIELD_BIT_COUNT, {26'd0, bits});
    write_reg(REG_BIG_ENDIAN, {31'd0, be});
    write_reg(REG_FULL_SCALE, fs);
    if (phase_no == 7) hold_off_req = 1'b1;
    field_end = off + bc;
    for (int unsigned f = 0; f < num_frames; f++) begin
      if (phase_no == 3) len = $urandom_range(250, 262);
      else if (phase_no == 11) len = $urandom_range(515, 540);
      else if (phase_no == 7) len = 1;
      else if (off > 6) len = $urandom_range(1, 48);
      else if ($urandom_range(4) == 0) len = $urandom_range(1, field_end);
      else len = field_end + $urandom_range(0, 3);
      send_frame(len);
      random_items += len;
    end
  endtask

  // Output side: random stalls, plus one long hold-off on request
  initial begin : receiver
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 7);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    angle_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (angle_q.size() == 0) begin
        $error("unexpected result: angle %h status %0b", m_axis_tdata, m_axis_tuser);
        failures++;
      end else begin
        want = angle_q.pop_front();
        if (m_axis_tdata !== want.angle) begin
          $error("angle: expected %h, actual %h", want.angle, m_axis_tdata);
          failures++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0b, actual %0b", want.status, m_axis_tuser);
          failures++;
        end
      end
    end
  end

  // End the run when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    angle_result_t typed_res;
    int unsigned   phase_no;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_FIELD_OFFSET;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    failures      = 0;
    stall_cycles  = 0;
    random_items  = 0;
    calm          = 1'b0;
    hold_off_req  = 1'b0;
    cfg_offset       = RST_FIELD_OFFSET;
    cfg_byte_count   = RST_FIELD_BYTE_COUNT;
    cfg_bit_count    = RST_FIELD_BIT_COUNT;
    cfg_big_endian   = RST_BIG_ENDIAN;
    cfg_full_scale   = RST_FULL_SCALE;
    frame_pos        = 0;
    field_acc        = '0;
    field_bytes_seen = 0;

    directed_rows = '{
      // Reset settings: two bytes little-endian, 16 bits, 2*pi
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'h00, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'h00, 1'b1, 1'b1, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'hFF, 1'b1, 1'b0, 32'h0, 1'b0},
      // Short frame
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'h12, 1'b1, 1'b1, 32'h0, 1'b1},
      // Byte count of zero, then seven
      '{ROW_CFG, REG_FIELD_BYTE_COUNT, 32'd0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'hAA, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'h55, 1'b1, 1'b1, 32'h0, 1'b1},
      '{ROW_CFG, REG_FIELD_BYTE_COUNT, 32'd7, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'h5A, 1'b1, 1'b1, 32'h0, 1'b1},
      // Widest field, full 32 bits, largest full scale
      '{ROW_CFG, REG_FIELD_BYTE_COUNT, 32'd4, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_CFG, REG_FIELD_BIT_COUNT, 32'd32, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_CFG, REG_BIG_ENDIAN, 32'd1, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_CFG, REG_FULL_SCALE, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'hFF, 1'b1, 1'b1, 32'hFFFF_FFFE, 1'b0},
      // Bit count of zero on a complete field
      '{ROW_CFG, REG_FIELD_BIT_COUNT, 32'd0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'h80, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'h00, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'h00, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'h01, 1'b1, 1'b1, 32'h0, 1'b1},
      // Bit count of 63 on a one-byte field
      '{ROW_CFG, REG_FIELD_BYTE_COUNT, 32'd1, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_CFG, REG_FIELD_BIT_COUNT, 32'd63, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'h77, 1'b1, 1'b1, 32'h0, 1'b1},
      // Single kept bit: mask drops all but bit zero
      '{ROW_CFG, REG_FIELD_BIT_COUNT, 32'd1, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_CFG, REG_FULL_SCALE, 32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'h01, 1'b1, 1'b1, 32'h4000_0000, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'hFE, 1'b1, 1'b1, 32'h0, 1'b0},
      // Offset field, little-endian, back to 2*pi
      '{ROW_CFG, REG_FIELD_OFFSET, 32'd2, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_CFG, REG_FIELD_BYTE_COUNT, 32'd3, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_CFG, REG_FIELD_BIT_COUNT, 32'd24, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_CFG, REG_BIG_ENDIAN, 32'd0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_CFG, REG_FULL_SCALE, 32'd0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'h11, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'h22, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'h33, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'h44, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'h55, 1'b0, 1'b0, 32'h0, 1'b0},
      '{ROW_ITEM, REG_FIELD_OFFSET, 32'h66, 1'b1, 1'b0, 32'h0, 1'b0}
    };

    // Hold reset, then release it on a falling edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    for (int unsigned i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        typed_res.angle  = directed_rows[i].exp_angle;
        typed_res.status = directed_rows[i].exp_status;
        send_item(directed_rows[i].value[7:0], directed_rows[i].last,
                  directed_rows[i].check, typed_res);
      end
    end

    // Random phases; a middle stretch runs with no idling on either side
    phase_no = 0;
    while (random_items < RANDOM_ITEMS || phase_no < MIN_PHASES) begin
      calm = (phase_no >= 14 && phase_no < 20);
      run_random_phase(phase_no);
      phase_no++;
    end
    calm = 1'b0;

    wait_idle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
